// ===== rtl/edsp_pkg.sv =====
// Shared types and constants of the EDID segment parser.
package edsp_pkg;

    localparam int BlocksPerSegment = 2;
    localparam int PosW = $clog2(BlocksPerSegment * 128 + 1);
    localparam int SegLimit = BlocksPerSegment * 128;

    localparam logic [6:0] DescFirst = 7'h36;
    localparam logic [6:0] DescLast = 7'h6C;
    localparam logic [7:0] RangeTag = 8'hFD;
    localparam logic [23:0] HdmiOui = 24'h000C03;
    localparam logic [6:0] CeaDtdLastStart = 7'h6D;

    typedef enum logic [3:0] {
        K_BASE = 4'd0, K_STD = 4'd1, K_DTD0 = 4'd2, K_DTD1 = 4'd3, K_DTD2 = 4'd4,
        K_RANGE = 4'd5, K_CEA = 4'd6, K_AUDIO = 4'd7, K_VIDEO = 4'd8, K_VENDOR = 4'd9
    } t_kind;

    typedef enum logic [1:0] {
        BK_NONE = 2'd0, BK_BASE = 2'd1, BK_CEA = 2'd2
    } t_block_kind;

    typedef enum logic [2:0] {
        J_NONE, J_BASE, J_STD, J_DTD, J_DESC, J_CEA, J_AUDIO, J_VIDEO
    } t_job_op;

    typedef enum logic [2:0] {
        T_RES0 = 3'd0, T_AUDIO = 3'd1, T_VIDEO = 3'd2, T_VENDOR = 3'd3, T_SPEAKER = 3'd4
    } t_tag;

    typedef struct packed {
        logic [7:0] edid_byte;
        logic       segment_start;
    } t_in;

    typedef struct packed {
        logic [3:0]  record_kind;
        logic [23:0] value_a;
        logic [15:0] value_b;
        logic [15:0] value_c;
        logic [15:0] value_d;
        logic [15:0] value_e;
        logic        last_of_run;
    } t_out;

    typedef struct packed {
        logic [3:0]  kind;
        logic [23:0] a;
        logic [15:0] b;
        logic [15:0] c;
        logic [15:0] d;
        logic [15:0] e;
    } t_rec;

    // One classified job: an opcode and a snapshot of the bytes it needs.
    typedef struct packed {
        t_job_op       op;
        logic [143:0]  data;
    } t_job;

    function automatic t_rec mk(input t_kind k, input logic [23:0] a, input logic [15:0] b,
                                input logic [15:0] c, input logic [15:0] d,
                                input logic [15:0] e);
        t_rec r;
        r.kind = k;
        r.a = a;
        r.b = b;
        r.c = c;
        r.d = d;
        r.e = e;
        return r;
    endfunction

endpackage

// ===== rtl/edsp_front.sv =====
// Front end: tracks segment position, captures bytes and issues record jobs.
module edsp_front
    import edsp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_in  i_data,
    output logic o_ready,
    output logic o_job_valid,
    output t_job o_job,
    input  logic i_job_ready
);

    logic [PosW-1:0] r_pos, n_pos, pos, pos_inc;
    t_block_kind r_bk, bk;
    logic [7:0] r_buf [18];
    logic [7:0] n_buf [18];
    logic r_hdr, n_hdr;
    logic [47:0] r_id, n_id;
    logic [7:0] r_tas, n_tas;
    logic [2:0] r_tag, n_tag;
    logic [4:0] r_left, n_left;
    logic r_done, n_done;
    logic [6:0] o;
    logic [7:0] b;
    logic acc;
    logic [4:0] rel;
    logic [4:0] idx;
    logic [1:0] m3;
    logic [7:0] diff;
    logic [6:0] dq;
    t_job job;
    logic [143:0] flat;

    assign o_ready = i_job_ready;
    assign acc = i_valid && o_ready;
    assign b = i_data.edid_byte;
    assign pos = i_data.segment_start ? '0 : r_pos;
    assign o = pos[6:0];
    assign pos_inc = pos + 1'b1;
    assign n_pos = (pos_inc >= PosW'(SegLimit)) ? '0 : pos_inc;

    always_comb begin
        bk = r_bk;
        if (o == 7'd0) begin
            if (pos[PosW-1:7] == '0 && b == 8'h00) bk = BK_BASE;
            else if (b == 8'h02) bk = BK_CEA;
            else bk = BK_NONE;
        end else if (o == 7'd1 && r_bk == BK_BASE && b != 8'hFF) begin
            bk = BK_NONE;
        end
    end

    always_comb begin
        n_buf = r_buf;
        n_hdr = (o == 7'd0) ? 1'b1 : r_hdr;
        n_id = r_id;
        n_tas = r_tas;
        n_tag = r_tag;
        n_left = r_left;
        n_done = r_done;
        job.op = J_NONE;
        rel = '0;
        idx = '0;
        m3 = '0;
        diff = {1'b0, o} - {1'b0, DescFirst};
        dq = '0;
        if (bk == BK_BASE) begin
            if (o < 7'd8) begin
                if (b != ((o == 7'd0 || o == 7'd7) ? 8'h00 : 8'hFF)) n_hdr = 1'b0;
            end else if (o == 7'h08) n_id[47:40] = b;
            else if (o == 7'h09) n_id[39:32] = b;
            else if (o == 7'h0A) n_id[23:16] = b;
            else if (o == 7'h0B) n_id[31:24] = b;
            else if (o == 7'h10) n_id[15:8] = b;
            else if (o == 7'h11) n_id[7:0] = b;
            else if (o == 7'h12) job.op = J_BASE;
            else if (o >= 7'h26 && o <= 7'h35) begin
                if (!o[0]) n_buf[0] = b;
                else job.op = J_STD;
            end else if (o >= DescFirst && o <= DescLast + 7'd17) begin
                dq = diff[6:0];
                if (dq >= 7'd54) rel = 5'(dq - 7'd54);
                else if (dq >= 7'd36) rel = 5'(dq - 7'd36);
                else if (dq >= 7'd18) rel = 5'(dq - 7'd18);
                else rel = dq[4:0];
                n_buf[rel] = b;
                if (rel == 5'd17) job.op = J_DESC;
            end
        end else if (bk == BK_CEA) begin
            if (o == 7'd0) begin
                n_done = 1'b0;
                n_left = '0;
                n_tag = '0;
            end else if (o == 7'd1) n_buf[0] = b;
            else if (o == 7'd2) n_tas = b;
            else if (o == 7'd3) job.op = J_CEA;
            else if ({1'b0, o} < r_tas && o < 7'd127) begin
                if (r_left == '0) begin
                    n_tag = b[7:5];
                    n_left = b[4:0];
                    for (int i = 0; i < 7; i++) n_buf[i] = 8'h00;
                    n_buf[17] = {3'b0, b[4:0]};
                end else begin
                    idx = r_buf[17][4:0] - r_left;
                    n_left = r_left - 1'b1;
                    m3 = (idx >= 5'd30) ? 2'(idx - 5'd30) : (idx >= 5'd27) ? 2'(idx - 5'd27) :
                         (idx >= 5'd24) ? 2'(idx - 5'd24) : (idx >= 5'd21) ? 2'(idx - 5'd21) :
                         (idx >= 5'd18) ? 2'(idx - 5'd18) : (idx >= 5'd15) ? 2'(idx - 5'd15) :
                         (idx >= 5'd12) ? 2'(idx - 5'd12) : (idx >= 5'd9) ? 2'(idx - 5'd9) :
                         (idx >= 5'd6) ? 2'(idx - 5'd6) : (idx >= 5'd3) ? 2'(idx - 5'd3) :
                         idx[1:0];
                    case (r_tag)
                        T_AUDIO: begin
                            n_buf[{3'b0, m3}] = b;
                            if (m3 == 2'd2) job.op = J_AUDIO;
                        end
                        T_VIDEO: job.op = J_VIDEO;
                        T_VENDOR: begin
                            if (idx < 5'd6) n_buf[idx] = b;
                            if (n_left == '0) job.op = J_BASE;
                        end
                        T_SPEAKER: if (idx == '0) job.op = J_VIDEO;
                        default: ;
                    endcase
                end
            end else if (!(r_tas < 8'd4 || {1'b0, o} < r_tas || r_done)) begin
                diff = {1'b0, o} - r_tas;
                dq = diff[6:0];
                if (dq >= 7'd108) rel = 5'(dq - 7'd108);
                else if (dq >= 7'd90) rel = 5'(dq - 7'd90);
                else if (dq >= 7'd72) rel = 5'(dq - 7'd72);
                else if (dq >= 7'd54) rel = 5'(dq - 7'd54);
                else if (dq >= 7'd36) rel = 5'(dq - 7'd36);
                else if (dq >= 7'd18) rel = 5'(dq - 7'd18);
                else rel = dq[4:0];
                if (rel == '0 && (b == 8'h00 || o > CeaDtdLastStart)) begin
                    n_done = 1'b1;
                end else begin
                    n_buf[rel] = b;
                    if (rel == 5'd17) job.op = J_DTD;
                end
            end
        end
        for (int i = 0; i < 18; i++) flat[i*8 +: 8] = n_buf[i];
        job.data = flat;
    end

    always_comb begin
        o_job = job;
        // Jobs carry context fields packed into unused slots.
        if (job.op == J_BASE && bk == BK_BASE)
            o_job.data = {r_hdr & n_hdr, 15'b0, n_id, 64'b0, b, 8'h00};
        else if (job.op == J_BASE)
            o_job.data = {flat[135:0], 8'hEE};
        else if (job.op == J_VIDEO)
            o_job.data = {flat[143:16], 5'b0, r_tag, b};
        else if (job.op == J_CEA)
            o_job.data = {flat[143:24], r_tas, b, 8'b0} | {136'b0, flat[7:0]};
        else if (job.op == J_AUDIO)
            o_job.data = {flat[143:32], flat[15:0], b, 8'b0};
        else if (job.op == J_STD)
            o_job.data = {flat[143:16], b, flat[7:0]};
    end

    assign o_job_valid = acc && job.op != J_NONE;

    always_ff @(posedge i_clk) begin
        if (acc) r_buf <= n_buf;
        if (!i_rst_n) begin
            r_pos <= '0;
            r_bk <= BK_NONE;
            r_hdr <= 1'b1;
            r_id <= '0;
            r_tas <= '0;
            r_tag <= '0;
            r_left <= '0;
            r_done <= 1'b0;
        end else if (acc) begin
            r_pos <= n_pos;
            r_bk <= bk;
            r_hdr <= n_hdr;
            r_id <= n_id;
            r_tas <= n_tas;
            r_tag <= n_tag;
            r_left <= n_left;
            r_done <= n_done;
        end
    end

endmodule

// ===== rtl/edsp_queue.sv =====
// Two-entry job queue between the front and back ends.
module edsp_queue
    import edsp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_job i_job,
    output logic o_ready,
    output logic o_valid,
    output t_job o_job,
    input  logic i_ready
);

    t_job r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_job = r_mem[r_rp];
    assign push = i_valid && o_ready;
    assign pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_job;
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== rtl/edsp_back.sv =====
// Back end: turns jobs into zero to three record beats.
module edsp_back
    import edsp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_job i_job,
    output logic o_ready,
    output logic o_valid,
    output t_out o_data,
    input  logic i_ready
);

    logic [7:0] p [18];
    t_rec rec [3];
    logic [1:0] cnt;
    logic [1:0] r_sub, n_sub;
    logic r_v;
    t_out r_out;
    logic load, step_done;
    logic [7:0] x11, b0, bb;
    logic [23:0] oui;
    logic gtf;

    always_comb begin
        for (int i = 0; i < 18; i++) p[i] = i_job.data[i*8 +: 8];
        x11 = p[11];
        b0 = p[0];
        bb = p[1];
        oui = {p[3], p[2], p[1]};
        gtf = p[10] == 8'd2;
        for (int i = 0; i < 3; i++) rec[i] = '0;
        cnt = 2'd1;
        unique case (i_job.op)
            J_BASE: begin
                if (p[0] == 8'hEE)
                    rec[0] = mk(K_VENDOR, oui, {p[4], p[5]},
                        16'(oui == HdmiOui), {8'b0, p[6]}, 16'd3);
                else
                    rec[0] = mk(K_BASE, {7'b0, p[17][7], p[15], p[14]}, {p[13], p[12]},
                        16'd1990 + {8'b0, p[10]}, {8'b0, p[11]}, {8'b0, p[1]});
            end
            J_STD: rec[0] = mk(K_STD, 24'(p[0]) * 24'd8 + 24'd248, {14'b0, bb[7:6]},
                16'(bb[5:0]) + 16'd60, '0, '0);
            J_AUDIO: rec[0] = mk(K_AUDIO, {20'b0, p[2][6:3]}, {12'b0, 1'b0, p[2][2:0]} + 16'd1,
                {9'b0, p[3][6:0]},
                (p[2][6:3] == 4'd1) ? {13'b0, bb[2:0]} : {5'b0, bb, 3'b0}, '0);
            J_VIDEO: begin
                if (p[1][2:0] == T_VIDEO)
                    rec[0] = mk(K_VIDEO, {17'b0, b0[6:0]}, {15'b0, b0[7]}, '0, '0, '0);
                else
                    rec[0] = mk(K_VENDOR, {17'b0, b0[6:0]}, '0, '0, '0, 16'd4);
            end
            J_CEA: rec[0] = mk(K_CEA, {16'b0, p[0]}, {8'b0, p[2]}, {12'b0, bb[7:4]},
                {12'b0, bb[3:0]}, '0);
            J_DESC, J_DTD: begin
                if (i_job.op == J_DESC && p[0] == 8'h00 && p[1] == 8'h00) begin
                    cnt = (p[3] == RangeTag) ? 2'd1 : 2'd0;
                    rec[0] = mk(K_RANGE, gtf ? 24'(p[12]) * 24'd2000 : 24'd0,
                        {p[5], p[6]}, {p[7], p[8]}, {gtf, 15'(16'(p[9]) * 16'd10)},
                        gtf ? {p[15], p[14]} : 16'd0);
                end else begin
                    cnt = 2'd3;
                    rec[0] = mk(K_DTD0, {8'b0, p[1], p[0]}, {4'b0, p[4][7:4], p[2]},
                        {4'b0, p[4][3:0], p[3]}, {4'b0, p[7][7:4], p[5]},
                        {4'b0, p[7][3:0], p[6]});
                    rec[1] = mk(K_DTD1, {12'b0, p[14][7:4], p[12]}, {6'b0, x11[7:6], p[8]},
                        {6'b0, x11[5:4], p[9]}, {10'b0, x11[3:2], p[10][7:4]},
                        {10'b0, x11[1:0], p[10][3:0]});
                    rec[2] = mk(K_DTD2, {12'b0, p[14][3:0], p[13]}, {8'b0, p[15]},
                        {8'b0, p[16]}, {8'b0, p[17]}, '0);
                end
            end
            default: cnt = 2'd0;
        endcase
    end

    assign load = !r_v || i_ready;
    assign step_done = (r_sub + 2'd1 >= cnt);
    assign o_ready = load && step_done;
    assign n_sub = step_done ? 2'd0 : r_sub + 2'd1;

    always_ff @(posedge i_clk) begin
        if (load && i_valid && cnt != 2'd0) begin
            r_out.record_kind <= rec[r_sub].kind;
            r_out.value_a <= rec[r_sub].a;
            r_out.value_b <= rec[r_sub].b;
            r_out.value_c <= rec[r_sub].c;
            r_out.value_d <= rec[r_sub].d;
            r_out.value_e <= rec[r_sub].e;
            r_out.last_of_run <= step_done;
        end
        if (!i_rst_n) begin
            r_v <= 1'b0;
            r_sub <= '0;
        end else if (load) begin
            r_v <= i_valid && cnt != 2'd0;
            if (i_valid) r_sub <= n_sub;
        end
    end

    assign o_valid = r_v;
    assign o_data = r_out;

endmodule

// ===== rtl/edsp_top.sv =====
// Top level of the EDID segment parser.
//  channel | dir | handshake
//  input   | in  | i_valid / o_ready, payload i_data
//  output  | out | o_valid / i_ready, payload o_data
// One byte is taken per cycle while the job queue has room; a detailed timing yields three output beats.
// The front stalls only when the two-entry job queue is full.
// Reset is synchronous and clears position and parser state.
module edid_segment_parser_top
    import edsp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_in  i_data,
    output logic o_ready,
    output logic o_valid,
    output t_out o_data,
    input  logic i_ready
);

    logic fj_v, fj_r, qb_v, qb_r;
    t_job fj, qb;

    edsp_front u_front (.i_clk, .i_rst_n, .i_valid, .i_data, .o_ready,
        .o_job_valid(fj_v), .o_job(fj), .i_job_ready(fj_r));
    edsp_queue u_queue (.i_clk, .i_rst_n, .i_valid(fj_v), .i_job(fj), .o_ready(fj_r),
        .o_valid(qb_v), .o_job(qb), .i_ready(qb_r));
    edsp_back u_back (.i_clk, .i_rst_n, .i_valid(qb_v), .i_job(qb), .o_ready(qb_r),
        .o_valid, .o_data, .i_ready);

endmodule

// ===== sim/tb_edid_segment_parser_top.sv =====
// Testbench for the EDID segment parser: scoreboard with a byte-level predictor.
module tb_edid_segment_parser_top;
    import edsp_pkg::*;

    localparam int unsigned FmtLpcm = 1;
    localparam int unsigned VendorTagE = 3;
    localparam int unsigned SpeakerTagE = 4;
    localparam int IdleLimit = 20000;
    localparam int HoldCycles = 200;

    class edid_record_board;
        bit [7:0]    position;
        t_block_kind blk_kind;
        bit [7:0]    dbuf[18];
        bit          hdr_ok;
        bit [47:0]   ident;
        bit [7:0]    tas;
        bit [2:0]    tag;
        bit [4:0]    left;
        bit          scan_done;
        t_out        pending_records[$];
        t_out        run[$];
        int          errors;

        function new();
            position = 0;
            blk_kind = BK_NONE;
            foreach (dbuf[i]) dbuf[i] = 0;
            hdr_ok = 1;
            ident = 0;
            tas = 0;
            tag = 0;
            left = 0;
            scan_done = 0;
            errors = 0;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function void put(t_kind k, int unsigned a, int unsigned b, int unsigned c,
                          int unsigned d, int unsigned e);
            t_out r;
            r.record_kind = k;
            r.value_a = a[23:0];
            r.value_b = b[15:0];
            r.value_c = c[15:0];
            r.value_d = d[15:0];
            r.value_e = e[15:0];
            r.last_of_run = 1'b0;
            run.push_back(r);
        endfunction

        function void timing_records();
            int unsigned x11;
            x11 = dbuf[11];
            put(K_DTD0, dbuf[0] | (dbuf[1] << 8), dbuf[2] | ((dbuf[4] >> 4) << 8),
                dbuf[3] | ((dbuf[4] & 15) << 8), dbuf[5] | ((dbuf[7] >> 4) << 8),
                dbuf[6] | ((dbuf[7] & 15) << 8));
            put(K_DTD1, dbuf[12] | ((dbuf[14] >> 4) << 8), dbuf[8] | (((x11 >> 6) & 3) << 8),
                dbuf[9] | (((x11 >> 4) & 3) << 8),
                (dbuf[10] >> 4) | (((x11 >> 2) & 3) << 4),
                (dbuf[10] & 15) | ((x11 & 3) << 4));
            put(K_DTD2, dbuf[13] | ((dbuf[14] & 15) << 8), dbuf[15], dbuf[16], dbuf[17], 0);
        endfunction

        function void descriptor_records();
            int unsigned gtf;
            if (dbuf[0] == 0 && dbuf[1] == 0) begin
                if (dbuf[3] != RangeTag) return;
                gtf = (dbuf[10] == 2) ? 1 : 0;
                put(K_RANGE, gtf ? dbuf[12] * 2000 : 0, (dbuf[5] << 8) | dbuf[6],
                    (dbuf[7] << 8) | dbuf[8], (gtf << 15) | (dbuf[9] * 10),
                    gtf ? (dbuf[14] | (dbuf[15] << 8)) : 0);
                return;
            end
            timing_records();
        endfunction

        function void base_byte(int unsigned o, int unsigned b);
            int unsigned want;
            int unsigned rel;
            if (o < 8) begin
                want = (o == 0 || o == 7) ? 0 : 'hFF;
                if (b != want) hdr_ok = 0;
                return;
            end
            case (o)
                'h08: begin ident[47:40] = b[7:0]; return; end
                'h09: begin ident[39:32] = b[7:0]; return; end
                'h0A: begin ident[23:16] = b[7:0]; return; end
                'h0B: begin ident[31:24] = b[7:0]; return; end
                'h10: begin ident[15:8] = b[7:0]; return; end
                'h11: begin ident[7:0] = b[7:0]; return; end
                'h12: begin
                    put(K_BASE, (hdr_ok << 16) | ident[47:32], ident[31:16],
                        1990 + ident[7:0], ident[15:8], b);
                    return;
                end
                default: ;
            endcase
            if (o >= 'h26 && o <= 'h35) begin
                if ((o & 1) == 0) dbuf[0] = b[7:0];
                else put(K_STD, dbuf[0] * 8 + 248, b >> 6, (b & 63) + 60, 0, 0);
                return;
            end
            if (o >= DescFirst && o <= DescLast + 17) begin
                rel = (o - DescFirst) % 18;
                dbuf[rel] = b[7:0];
                if (rel == 17) descriptor_records();
            end
        endfunction

        function void data_block_byte(int unsigned b);
            int unsigned idx;
            int unsigned fmt;
            int unsigned oui;
            if (left == 0) begin
                tag = b[7:5];
                left = b[4:0];
                for (int i = 0; i < 7; i++) dbuf[i] = 0;
                dbuf[17] = {3'b0, left};
                return;
            end
            idx = (dbuf[17] - left) & 31;
            left--;
            case (tag)
                T_AUDIO: begin
                    dbuf[idx % 3] = b[7:0];
                    if (idx % 3 == 2) begin
                        fmt = (dbuf[0] >> 3) & 15;
                        put(K_AUDIO, fmt, (dbuf[0] & 7) + 1, dbuf[1] & 'h7F,
                            fmt == FmtLpcm ? (b & 7) : b * 8, 0);
                    end
                end
                T_VIDEO: put(K_VIDEO, b & 'h7F, b >> 7, 0, 0, 0);
                T_VENDOR: begin
                    if (idx < 6) dbuf[idx] = b[7:0];
                    if (left == 0) begin
                        oui = dbuf[0] | (dbuf[1] << 8) | (dbuf[2] << 16);
                        put(K_VENDOR, oui, (dbuf[3] << 8) | dbuf[4],
                            oui == HdmiOui ? 1 : 0, dbuf[5], VendorTagE);
                    end
                end
                T_SPEAKER: if (idx == 0) put(K_VENDOR, b & 'h7F, 0, 0, 0, SpeakerTagE);
                default: ;
            endcase
        endfunction

        function void cea_byte(int unsigned o, int unsigned b);
            int unsigned rel;
            case (o)
                0: begin scan_done = 0; left = 0; tag = 0; return; end
                1: begin dbuf[0] = b[7:0]; return; end
                2: begin tas = b[7:0]; return; end
                3: begin put(K_CEA, dbuf[0], tas, b >> 4, b & 15, 0); return; end
                default: ;
            endcase
            if (o < tas && o < 127) begin
                data_block_byte(b);
                return;
            end
            if (tas < 4 || o < tas || scan_done) return;
            rel = (o - tas) % 18;
            if (rel == 0 && (b == 0 || o > CeaDtdLastStart)) begin
                scan_done = 1;
                return;
            end
            dbuf[rel] = b[7:0];
            if (rel == 17) timing_records();
        endfunction

        function void take_byte(t_in d);
            int unsigned b;
            int unsigned pos;
            int unsigned o;
            b = d.edid_byte;
            pos = d.segment_start ? 0 : position;
            o = pos & 127;
            run.delete();
            if (o == 0) begin
                hdr_ok = 1;
                if ((pos >> 7) == 0 && b == 0) blk_kind = BK_BASE;
                else if (b == 2) blk_kind = BK_CEA;
                else blk_kind = BK_NONE;
            end else if (o == 1 && blk_kind == BK_BASE && b != 'hFF) begin
                blk_kind = BK_NONE;
            end
            if (blk_kind == BK_BASE) base_byte(o, b);
            else if (blk_kind == BK_CEA) cea_byte(o, b);
            if (run.size() > 0) run[run.size() - 1].last_of_run = 1'b1;
            foreach (run[i]) pending_records.push_back(run[i]);
            pos++;
            position = (pos >= SegLimit) ? 8'd0 : pos[7:0];
        endfunction

        task cmp_field(string f, longint unsigned got, longint unsigned want);
            if (got != want) report($sformatf("%s got %0h want %0h", f, got, want));
        endtask

        task check_record(t_out r);
            t_out w;
            if (pending_records.size() == 0) begin
                report($sformatf("unexpected record kind %0d", r.record_kind));
                return;
            end
            w = pending_records.pop_front();
            cmp_field("record_kind", r.record_kind, w.record_kind);
            cmp_field("value_a", r.value_a, w.value_a);
            cmp_field("value_b", r.value_b, w.value_b);
            cmp_field("value_c", r.value_c, w.value_c);
            cmp_field("value_d", r.value_d, w.value_d);
            cmp_field("value_e", r.value_e, w.value_e);
            cmp_field("last_of_run", r.last_of_run, w.last_of_run);
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    t_in  i_data;
    logic o_ready;
    logic o_valid;
    t_out o_data;
    logic i_ready;

    edid_record_board board;
    bit tx_gaps;
    bit rx_gaps;
    bit hold_req;
    int idle_cycles;
    bit [7:0] seg[256];

    edid_segment_parser_top dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .i_data(i_data),
        .o_ready(o_ready),
        .o_valid(o_valid),
        .o_data(o_data),
        .i_ready(i_ready)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        int hold_left;
        hold_left = 0;
        i_ready = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && i_valid && o_ready) board.take_byte(i_data);
            if (i_rst_n && o_valid && i_ready) board.check_record(o_data);
            if (hold_req) begin
                hold_req = 0;
                hold_left = HoldCycles;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= !(rx_gaps && $urandom_range(99) < 30);
            end
        end
    end

    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IdleLimit) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task send_byte(input bit [7:0] b, input bit s);
        t_in d;
        d.edid_byte = b;
        d.segment_start = s;
        while (tx_gaps && $urandom_range(99) < 30) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= d;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending_records.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function void build_segment();
        int at;
        int p;
        int t;
        int len;
        int target;
        int tstart;
        foreach (seg[i]) seg[i] = 8'($urandom);
        t = $urandom_range(9);
        if (t < 7) begin
            seg[0] = 0;
            for (int i = 1; i < 7; i++) seg[i] = 8'hFF;
            seg[7] = 0;
            if ($urandom_range(5) == 0) seg[$urandom_range(1, 7)] = 8'($urandom);
            for (int k = 0; k < 4; k++) begin
                at = DescFirst + 18 * k;
                case ($urandom_range(3))
                    0: if (seg[at] == 0 && seg[at + 1] == 0) seg[at] = 1;
                    1: begin
                        seg[at] = 0;
                        seg[at + 1] = 0;
                        seg[at + 3] = RangeTag;
                        if ($urandom_range(1)) seg[at + 10] = 2;
                    end
                    2: begin seg[at] = 0; seg[at + 1] = 0; end
                    default: ;
                endcase
            end
        end else if (t == 7) begin
            seg[0] = 2;
        end
        if ($urandom_range(9) < 8) begin
            seg[128] = 2;
            p = 4;
            target = $urandom_range(4, 36);
            while (p < target) begin
                t = $urandom_range(7);
                len = $urandom_range(12);
                seg[128 + p] = {t[2:0], len[4:0]};
                if (t == T_VENDOR && $urandom_range(1)) begin
                    seg[128 + p + 1] = 8'h03;
                    seg[128 + p + 2] = 8'h0C;
                    seg[128 + p + 3] = 8'h00;
                end
                p += 1 + len;
            end
            tstart = ($urandom_range(99) < 85) ? p : $urandom_range(127);
            seg[130] = 8'(tstart);
            for (int q = tstart; q + 18 <= 127; q += 18) begin
                if (q < 4) break;
                seg[128 + q] = ($urandom_range(9) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
            end
        end
    endfunction

    task send_span(input int first, input int count, input bit mark);
        for (int i = 0; i < count; i++) send_byte(seg[first + i], (i == 0) ? mark : 1'b0);
    endtask

    initial begin
        board = new();
        tx_gaps = 1;
        rx_gaps = 1;
        hold_req = 0;
        i_rst_n = 0;
        i_valid = 0;
        i_data = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h02, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h02, 1'b1);
        send_byte(8'h03, 1'b0);
        send_byte(8'h0A, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h63, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'h0C, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hE1, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h01, 1'b0);
        drain();

        build_segment();
        tx_gaps = 0;
        rx_gaps = 0;
        hold_req = 1;
        send_span(0, 128, 1'b1);
        drain();

        tx_gaps = 1;
        rx_gaps = 1;
        build_segment();
        send_span(128, 76, 1'b1);
        drain();

        if (board.pending_records.size() > 0)
            board.report($sformatf("%0d records never came", board.pending_records.size()));
        if (board.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
